@@ design/vrfl_pkg.sv @@
// ---------------------------------------------------------------------------
// vrfl_pkg
// Shared types, request codes and helpers of the rectangle fill/copy blitter.
// ---------------------------------------------------------------------------
package vrfl_pkg;

	localparam int MEM_COLS_DEF = 1024;
	localparam int MEM_ROWS_DEF = 512;
	localparam int MEM_DIM_MAX  = 4096;
	localparam int DIM_W        = $clog2(MEM_DIM_MAX);
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [2:0] REQ_FILL       = 3'd0;
	localparam logic [2:0] REQ_LOAD_BEGIN = 3'd1;
	localparam logic [2:0] REQ_LOAD_PIXEL = 3'd2;
	localparam logic [2:0] REQ_MOVE       = 3'd3;
	localparam logic [2:0] REQ_READ       = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FILL,
		OP_MOVE,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [DIM_W-1:0] src_col;
		logic [DIM_W-1:0] src_row;
		logic [DIM_W-1:0] dst_col;
		logic [DIM_W-1:0] dst_row;
		logic [10:0]      width;
		logic [9:0]       height;
		logic [15:0]      data;
		logic             load_open;
		logic             stray;
	} entry_t;

	// reduce a coordinate below 2^10 modulo m (m >= 16) by binary long division
	function automatic logic [DIM_W-1:0] wrap_coord(input logic [DIM_W-1:0] v,
	                                                input logic [DIM_W:0]   m);
		logic [DIM_W+7:0] acc;
		logic [DIM_W+7:0] step;
		acc = {8'b0, v};
		for (int k = 6; k >= 0; k--) begin
			step = {7'b0, m} << k;
			if (acc >= step) begin
				acc = acc - step;
			end
		end
		return acc[DIM_W-1:0];
	endfunction

	function automatic logic [15:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
	                                         input logic [7:0] b);
		return {1'b0, b[7:3], g[7:3], r[7:3]};
	endfunction

endpackage

@@ design/vram_rect_fill_load_copy_unit.sv @@
// ---------------------------------------------------------------------------
// vram_rect_fill_load_copy_unit
// Rectangle fill, load and copy blitter over a 16-bit-pixel video memory.
// ---------------------------------------------------------------------------
// A request is queued, then popped when the back is idle; its result beat is registered
// at the pop, or after the read-wait state for a read. Other beats pop 1 per cycle while
// the back is idle. Fill and move walk w*h pixels, one memory port pair per pixel.
// A 4-entry command queue holds off start (busy) only while it is full.
// The receiver cannot stall: done is a one-cycle strobe, results come in request order.
// Reset clears the queue, load tracking and sequencer; video memory is not cleared.
module vram_rect_fill_load_copy_unit #(
	parameter int MEM_COLS = vrfl_pkg::MEM_COLS_DEF,
	parameter int MEM_ROWS = vrfl_pkg::MEM_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [9:0]  x,
	input  logic [8:0]  y,
	input  logic [10:0] width,
	input  logic [9:0]  height,
	input  logic [9:0]  dest_x,
	input  logic [8:0]  dest_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [15:0] pixel,
	output logic        done,
	output logic [15:0] read_data,
	output logic        load_open,
	output logic        stray_pixel
);

	vrfl_pkg::entry_t push_entry, head;
	logic             accept, q_full, q_empty, pop;

	assign busy   = q_full;
	assign accept = start && !q_full;

	vrfl_front #(
		.MEM_COLS (MEM_COLS),
		.MEM_ROWS (MEM_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.x        (x),
		.y        (y),
		.width    (width),
		.height   (height),
		.dest_x   (dest_x),
		.dest_y   (dest_y),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.pixel    (pixel),
		.entry    (push_entry)
	);

	vrfl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	vrfl_back #(
		.MEM_COLS (MEM_COLS),
		.MEM_ROWS (MEM_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.done        (done),
		.read_data   (read_data),
		.load_open   (load_open),
		.stray_pixel (stray_pixel)
	);

	a_stray_closed: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(stray_pixel && load_open))
		else $error("stray pixel reported while a load is open");

	a_stray_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && stray_pixel) |-> (read_data == 16'd0))
		else $error("stray pixel beat carries read data");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !done)
		else $error("result beat during reset");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("back took a command from an empty queue");

endmodule

@@ design/vrfl_front.sv @@
// ---------------------------------------------------------------------------
// vrfl_front
// Classifies requests, wraps coordinates and tracks the open load rectangle.
// ---------------------------------------------------------------------------
module vrfl_front #(
	parameter int MEM_COLS = vrfl_pkg::MEM_COLS_DEF,
	parameter int MEM_ROWS = vrfl_pkg::MEM_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [2:0]       req_type,
	input  logic [9:0]       x,
	input  logic [8:0]       y,
	input  logic [10:0]      width,
	input  logic [9:0]       height,
	input  logic [9:0]       dest_x,
	input  logic [8:0]       dest_y,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic [15:0]      pixel,
	output vrfl_pkg::entry_t entry
);

	localparam int CW  = $clog2(MEM_COLS);
	localparam int RW  = $clog2(MEM_ROWS);
	localparam int DW  = vrfl_pkg::DIM_W;
	localparam int DW1 = DW + 1;
	localparam logic [DW:0] COLS_V = DW1'(MEM_COLS);
	localparam logic [DW:0] ROWS_V = DW1'(MEM_ROWS);

	logic          load_active_q, act_n;
	logic [CW-1:0] org_col_q, org_col_n;
	logic [CW-1:0] cur_col_q, cur_col_n;
	logic [RW-1:0] cur_row_q, cur_row_n;
	logic [10:0]   span_q, span_n;
	logic [9:0]    rows_q, rows_n;
	logic [9:0]    col_off_q, col_off_n;
	logic [9:0]    row_off_q, row_off_n;

	logic [CW-1:0] x_w, dx_w, col_inc;
	logic [RW-1:0] y_w, dy_w, row_inc;
	logic          col_last, row_last;

	assign x_w  = CW'(vrfl_pkg::wrap_coord(DW'(x), COLS_V));
	assign dx_w = CW'(vrfl_pkg::wrap_coord(DW'(dest_x), COLS_V));
	assign y_w  = RW'(vrfl_pkg::wrap_coord(DW'(y), ROWS_V));
	assign dy_w = RW'(vrfl_pkg::wrap_coord(DW'(dest_y), ROWS_V));

	assign col_inc  = (cur_col_q == CW'(MEM_COLS - 1)) ? '0 : cur_col_q + 1'b1;
	assign row_inc  = (cur_row_q == RW'(MEM_ROWS - 1)) ? '0 : cur_row_q + 1'b1;
	assign col_last = ({1'b0, col_off_q} + 11'd1) >= span_q;
	assign row_last = ({1'b0, row_off_q} + 11'd1) >= {1'b0, rows_q};

	always_comb begin
		act_n     = load_active_q;
		org_col_n = org_col_q;
		cur_col_n = cur_col_q;
		cur_row_n = cur_row_q;
		span_n    = span_q;
		rows_n    = rows_q;
		col_off_n = col_off_q;
		row_off_n = row_off_q;

		entry.op      = vrfl_pkg::OP_NONE;
		entry.src_col = DW'(x_w);
		entry.src_row = DW'(y_w);
		entry.dst_col = DW'(dx_w);
		entry.dst_row = DW'(dy_w);
		entry.width   = width;
		entry.height  = height;
		entry.data    = pixel;
		entry.stray   = 1'b0;

		unique case (req_type)
			vrfl_pkg::REQ_FILL: begin
				entry.op   = vrfl_pkg::OP_FILL;
				entry.data = vrfl_pkg::pack_rgb(red, green, blue);
				act_n      = 1'b0;
			end
			vrfl_pkg::REQ_LOAD_BEGIN: begin
				act_n     = (width != 11'd0) && (height != 10'd0);
				org_col_n = x_w;
				cur_col_n = x_w;
				cur_row_n = y_w;
				span_n    = width;
				rows_n    = height;
				col_off_n = '0;
				row_off_n = '0;
			end
			vrfl_pkg::REQ_LOAD_PIXEL: begin
				if (!load_active_q) begin
					entry.stray = 1'b1;
				end else begin
					entry.op      = vrfl_pkg::OP_WRITE;
					entry.src_col = DW'(cur_col_q);
					entry.src_row = DW'(cur_row_q);
					if (col_last) begin
						col_off_n = '0;
						cur_col_n = org_col_q;
						cur_row_n = row_inc;
						if (row_last) begin
							row_off_n = '0;
							act_n     = 1'b0;
						end else begin
							row_off_n = row_off_q + 1'b1;
						end
					end else begin
						col_off_n = col_off_q + 1'b1;
						cur_col_n = col_inc;
					end
				end
			end
			vrfl_pkg::REQ_MOVE: begin
				entry.op = vrfl_pkg::OP_MOVE;
				act_n    = 1'b0;
			end
			vrfl_pkg::REQ_READ: begin
				entry.op = vrfl_pkg::OP_READ;
			end
			default: begin
			end
		endcase

		entry.load_open = act_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_active_q <= 1'b0;
			org_col_q     <= '0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			span_q        <= '0;
			rows_q        <= '0;
			col_off_q     <= '0;
			row_off_q     <= '0;
		end else if (accept) begin
			load_active_q <= act_n;
			org_col_q     <= org_col_n;
			cur_col_q     <= cur_col_n;
			cur_row_q     <= cur_row_n;
			span_q        <= span_n;
			rows_q        <= rows_n;
			col_off_q     <= col_off_n;
			row_off_q     <= row_off_n;
		end
	end

endmodule

@@ design/vrfl_queue.sv @@
// ---------------------------------------------------------------------------
// vrfl_queue
// Small register queue of classified commands between front and back.
// ---------------------------------------------------------------------------
module vrfl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vrfl_pkg::entry_t push_entry,
	input  logic             pop,
	output vrfl_pkg::entry_t head,
	output logic             full,
	output logic             empty
);

	localparam int D    = vrfl_pkg::QUEUE_DEPTH;
	localparam int PW   = $clog2(D);
	localparam int CNTW = $clog2(D + 1);

	vrfl_pkg::entry_t entries_q [D];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full  = (count_q == CNTW'(D));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/vrfl_back.sv @@
// ---------------------------------------------------------------------------
// vrfl_back
// Executes commands against the video memory and issues one result beat each.
// ---------------------------------------------------------------------------
module vrfl_back #(
	parameter int MEM_COLS = vrfl_pkg::MEM_COLS_DEF,
	parameter int MEM_ROWS = vrfl_pkg::MEM_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vrfl_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             done,
	output logic [15:0]      read_data,
	output logic             load_open,
	output logic             stray_pixel
);

	localparam int CW    = $clog2(MEM_COLS);
	localparam int RW    = $clog2(MEM_ROWS);
	localparam int DEPTH = MEM_COLS * MEM_ROWS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		B_IDLE,
		B_FILL,
		B_MOVE,
		B_DRAIN,
		B_READ_WAIT
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] col,
	                                          input logic [RW-1:0] row);
		return AW'(row) * AW'(MEM_COLS) + AW'(col);
	endfunction

	logic [15:0] mem [DEPTH];

	state_t        state_q;
	logic          done_q, load_open_q, stray_q;
	logic [15:0]   read_data_q;
	logic          pend_q, fwd_q;
	logic [AW-1:0] pend_addr_q;
	logic [15:0]   fwd_data_q, rdata_q, colour_q;
	logic [CW-1:0] src_col_q, dst_col_q, org_src_col_q, org_dst_col_q;
	logic [RW-1:0] src_row_q, dst_row_q;
	logic [10:0]   w_q, c_q;
	logic [9:0]    h_q, r_q;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr, head_addr;
	logic [15:0]   wr_data, eff_data;
	logic          nonempty, walk_end_col, walk_end;
	logic [CW-1:0] src_col_inc, dst_col_inc;
	logic [RW-1:0] src_row_inc, dst_row_inc;

	assign pop          = (state_q == B_IDLE) && !empty;
	assign nonempty     = (head.width != 11'd0) && (head.height != 10'd0);
	assign head_addr    = addr_of(CW'(head.src_col), RW'(head.src_row));
	assign eff_data     = fwd_q ? fwd_data_q : rdata_q;
	assign walk_end_col = (c_q + 11'd1) == w_q;
	assign walk_end     = walk_end_col && (({1'b0, r_q} + 11'd1) == {1'b0, h_q});

	assign src_col_inc = (src_col_q == CW'(MEM_COLS - 1)) ? '0 : src_col_q + 1'b1;
	assign dst_col_inc = (dst_col_q == CW'(MEM_COLS - 1)) ? '0 : dst_col_q + 1'b1;
	assign src_row_inc = (src_row_q == RW'(MEM_ROWS - 1)) ? '0 : src_row_q + 1'b1;
	assign dst_row_inc = (dst_row_q == RW'(MEM_ROWS - 1)) ? '0 : dst_row_q + 1'b1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = eff_data;
		rd_en   = 1'b0;
		rd_addr = addr_of(src_col_q, src_row_q);
		if (pend_q) begin
			wr_en = 1'b1;
		end
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					case (head.op)
						vrfl_pkg::OP_WRITE: begin
							wr_en   = 1'b1;
							wr_addr = head_addr;
							wr_data = head.data;
						end
						vrfl_pkg::OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = head_addr;
						end
						default: begin
						end
					endcase
				end
			end
			B_FILL: begin
				wr_en   = 1'b1;
				wr_addr = addr_of(src_col_q, src_row_q);
				wr_data = colour_q;
			end
			B_MOVE: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			done_q      <= 1'b0;
			read_data_q <= '0;
			load_open_q <= 1'b0;
			stray_q     <= 1'b0;
			pend_q      <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pend_q <= (state_q == B_MOVE);
			fwd_q  <= rd_en && wr_en && (rd_addr == wr_addr);
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						load_open_q <= head.load_open;
						stray_q     <= head.stray;
						read_data_q <= '0;
						case (head.op)
							vrfl_pkg::OP_READ: begin
								state_q <= B_READ_WAIT;
							end
							vrfl_pkg::OP_FILL: begin
								done_q <= 1'b1;
								if (nonempty) begin
									state_q <= B_FILL;
								end
							end
							vrfl_pkg::OP_MOVE: begin
								done_q <= 1'b1;
								if (nonempty) begin
									state_q <= B_MOVE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				B_FILL: begin
					if (walk_end) begin
						state_q <= B_IDLE;
					end
				end
				B_MOVE: begin
					if (walk_end) begin
						state_q <= B_DRAIN;
					end
				end
				B_DRAIN: begin
					state_q <= B_IDLE;
				end
				B_READ_WAIT: begin
					done_q      <= 1'b1;
					read_data_q <= eff_data;
					state_q     <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_q <= addr_of(dst_col_q, dst_row_q);
		fwd_data_q  <= wr_data;
		if (pop) begin
			src_col_q     <= CW'(head.src_col);
			src_row_q     <= RW'(head.src_row);
			dst_col_q     <= CW'(head.dst_col);
			dst_row_q     <= RW'(head.dst_row);
			org_src_col_q <= CW'(head.src_col);
			org_dst_col_q <= CW'(head.dst_col);
			w_q           <= head.width;
			h_q           <= head.height;
			c_q           <= '0;
			r_q           <= '0;
			colour_q      <= head.data;
		end else if ((state_q == B_FILL) || (state_q == B_MOVE)) begin
			if (walk_end_col) begin
				c_q       <= '0;
				r_q       <= r_q + 1'b1;
				src_col_q <= org_src_col_q;
				dst_col_q <= org_dst_col_q;
				src_row_q <= src_row_inc;
				dst_row_q <= dst_row_inc;
			end else begin
				c_q       <= c_q + 1'b1;
				src_col_q <= src_col_inc;
				dst_col_q <= dst_col_inc;
			end
		end
	end

	assign done        = done_q;
	assign read_data   = read_data_q;
	assign load_open   = load_open_q;
	assign stray_pixel = stray_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle fill/load/copy blitter. A short table
// of directed requests covers color extremes, wrap at every memory edge, the
// load sequence and its abandon rules, stray pixels and unused request codes.
// Random traffic follows, mostly complete load sequences, fills, copies and
// reads of pixels known to be written. Each done beat is checked against the
// typed response of its table row or a shadow of video memory and load state.
// ---------------------------------------------------------------------------
module testbench;

	localparam int VRAM_COLS       = vrfl_pkg::MEM_COLS_DEF;
	localparam int VRAM_ROWS       = vrfl_pkg::MEM_ROWS_DEF;
	localparam int VRAM_CELLS      = VRAM_COLS * VRAM_ROWS;
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_BEATS    = 1300;
	localparam int SPOT_LOG_DEPTH  = 512;
	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic [2:0]  req;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [10:0] w;
		logic [9:0]  h;
		logic [9:0]  dx;
		logic [8:0]  dy;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [15:0] pix;
	} blit_cmd_t;

	typedef struct packed {
		logic [15:0] data;
		logic        load_flag;
		logic        stray;
	} blit_resp_t;

	typedef struct {
		blit_cmd_t  cmd;
		bit         typed;
		blit_resp_t want;
	} tab_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [9:0]  x;
	logic [8:0]  y;
	logic [10:0] width;
	logic [9:0]  height;
	logic [9:0]  dest_x;
	logic [8:0]  dest_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] pixel;
	logic        done;
	logic [15:0] read_data;
	logic        load_open;
	logic        stray_pixel;

	vram_rect_fill_load_copy_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.x(x),
		.y(y),
		.width(width),
		.height(height),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.red(red),
		.green(green),
		.blue(blue),
		.pixel(pixel),
		.done(done),
		.read_data(read_data),
		.load_open(load_open),
		.stray_pixel(stray_pixel)
	);

	// shadow of video memory and load tracking
	logic [15:0] vram [VRAM_CELLS];
	bit          vram_ok [VRAM_CELLS];
	bit          load_on;
	int          org_col;
	int          org_row;
	int          span;
	int          rows;
	int          col_ofs;
	int          row_ofs;
	int          spot_log [$];

	blit_resp_t  resp_due [$];
	tab_row_t    dir_tab [$];
	int          mismatch_count;
	int          stall_cycles;
	bit          calm;
	int          kind_tally [8];
	int          stray_tally;
	int          spare_tally;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int spot(int col, int row);
		return (row % VRAM_ROWS) * VRAM_COLS + (col % VRAM_COLS);
	endfunction

	task automatic note_spot(input int idx);
		if (spot_log.size() < SPOT_LOG_DEPTH) begin
			spot_log.push_back(idx);
		end else begin
			spot_log[$urandom_range(SPOT_LOG_DEPTH - 1)] = idx;
		end
	endtask

	task automatic emulate_blit(input blit_cmd_t c, output blit_resp_t res);
		int i;
		int j;
		int s;
		int d;
		logic [15:0] color;
		res = '0;
		case (c.req)
			vrfl_pkg::REQ_FILL: begin
				color = {1'b0, c.b[7:3], c.g[7:3], c.r[7:3]};
				load_on = 1'b0;
				for (j = 0; j < int'(c.h); j++) begin
					for (i = 0; i < int'(c.w); i++) begin
						d = spot(int'(c.x) + i, int'(c.y) + j);
						vram[d] = color;
						vram_ok[d] = 1'b1;
						note_spot(d);
					end
				end
			end
			vrfl_pkg::REQ_LOAD_BEGIN: begin
				load_on = (c.w != 0) && (c.h != 0);
				org_col = int'(c.x);
				org_row = int'(c.y);
				span = int'(c.w);
				rows = int'(c.h);
				col_ofs = 0;
				row_ofs = 0;
			end
			vrfl_pkg::REQ_LOAD_PIXEL: begin
				if (!load_on) begin
					res.stray = 1'b1;
				end else begin
					d = spot(org_col + col_ofs, org_row + row_ofs);
					vram[d] = c.pix;
					vram_ok[d] = 1'b1;
					note_spot(d);
					col_ofs++;
					if (col_ofs >= span) begin
						col_ofs = 0;
						row_ofs++;
						if (row_ofs >= rows) begin
							row_ofs = 0;
							load_on = 1'b0;
						end
					end
				end
			end
			vrfl_pkg::REQ_MOVE: begin
				load_on = 1'b0;
				for (j = 0; j < int'(c.h); j++) begin
					for (i = 0; i < int'(c.w); i++) begin
						s = spot(int'(c.x) + i, int'(c.y) + j);
						d = spot(int'(c.dx) + i, int'(c.dy) + j);
						vram[d] = vram[s];
						vram_ok[d] = vram_ok[s];
						if (vram_ok[d]) begin
							note_spot(d);
						end
					end
				end
			end
			vrfl_pkg::REQ_READ: begin
				res.data = vram[spot(int'(c.x), int'(c.y))];
			end
			default: begin
			end
		endcase
		res.load_flag = load_on;
	endtask

	function automatic blit_cmd_t mk(logic [2:0] req, int cx, int cy, int cw, int ch,
	                                 int cdx, int cdy, int cr, int cg, int cb, int cpix);
		blit_cmd_t c;
		c.req = req;
		c.x = 10'(cx);
		c.y = 9'(cy);
		c.w = 11'(cw);
		c.h = 10'(ch);
		c.dx = 10'(cdx);
		c.dy = 9'(cdy);
		c.r = 8'(cr);
		c.g = 8'(cg);
		c.b = 8'(cb);
		c.pix = 16'(cpix);
		return c;
	endfunction

	function automatic void add_row(blit_cmd_t c, bit typed, blit_resp_t want);
		tab_row_t row;
		row.cmd = c;
		row.typed = typed;
		row.want = want;
		dir_tab.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
	                             input logic [15:0] want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	task automatic send_cmd(input blit_cmd_t c, input bit typed, input blit_resp_t want);
		blit_resp_t got;
		while (!calm && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		req_type <= c.req;
		x        <= c.x;
		y        <= c.y;
		width    <= c.w;
		height   <= c.h;
		dest_x   <= c.dx;
		dest_y   <= c.dy;
		red      <= c.r;
		green    <= c.g;
		blue     <= c.b;
		pixel    <= c.pix;
		@(posedge clk);
		while (busy) @(posedge clk);
		emulate_blit(c, got);
		resp_due.push_back(typed ? want : got);
		kind_tally[c.req]++;
		if (got.stray) begin
			stray_tally++;
		end
		if (c.req > vrfl_pkg::REQ_READ) begin
			spare_tally++;
		end
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (resp_due.size() != 0) @(posedge clk);
	endtask

	task automatic pick_random_cmd(output blit_cmd_t c);
		int roll;
		int k;
		int idx;
		bit found;
		c.x = 10'($urandom);
		c.y = 9'($urandom);
		c.dx = 10'($urandom);
		c.dy = 9'($urandom);
		c.r = 8'($urandom);
		c.g = 8'($urandom);
		c.b = 8'($urandom);
		c.pix = 16'($urandom);
		c.w = '0;
		c.h = '0;
		roll = $urandom_range(99);
		if (load_on) begin
			if (roll < 82) c.req = vrfl_pkg::REQ_LOAD_PIXEL;
			else if (roll < 92) c.req = vrfl_pkg::REQ_READ;
			else if (roll < 94) c.req = vrfl_pkg::REQ_FILL;
			else if (roll < 96) c.req = vrfl_pkg::REQ_MOVE;
			else if (roll < 98) c.req = vrfl_pkg::REQ_LOAD_BEGIN;
			else c.req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end else begin
			if (roll < 22) c.req = vrfl_pkg::REQ_FILL;
			else if (roll < 42) c.req = vrfl_pkg::REQ_LOAD_BEGIN;
			else if (roll < 57) c.req = vrfl_pkg::REQ_MOVE;
			else if (roll < 85) c.req = vrfl_pkg::REQ_READ;
			else if (roll < 93) c.req = vrfl_pkg::REQ_LOAD_PIXEL;
			else c.req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		// read only pixels that hold a known value
		if (c.req == vrfl_pkg::REQ_READ) begin
			found = 1'b0;
			idx = 0;
			for (k = 0; k < 16 && !found && spot_log.size() > 0; k++) begin
				idx = spot_log[$urandom_range(spot_log.size() - 1)];
				found = vram_ok[idx];
			end
			if (found) begin
				c.x = 10'(idx % VRAM_COLS);
				c.y = 9'(idx / VRAM_COLS);
			end else begin
				c.req = vrfl_pkg::REQ_FILL;
			end
		end
		case (c.req)
			vrfl_pkg::REQ_FILL, vrfl_pkg::REQ_MOVE: begin
				roll = $urandom_range(199);
				if (roll < 6) begin
					c.w = ($urandom_range(1) != 0) ? '0 : 11'($urandom_range(1, 8));
					c.h = (c.w == 0) ? 10'($urandom_range(0, 8)) : '0;
				end else if (roll < 190) begin
					c.w = 11'($urandom_range(1, 8));
					c.h = 10'($urandom_range(1, 8));
				end else if (roll < 196) begin
					c.w = 11'($urandom_range(1, 40));
					c.h = 10'($urandom_range(1, 40));
				end else if (roll < 198) begin
					c.w = 11'($urandom_range(1, VRAM_COLS));
					c.h = 10'($urandom_range(1, 2));
				end else begin
					c.w = 11'($urandom_range(1, 2));
					c.h = 10'($urandom_range(1, VRAM_ROWS));
				end
			end
			vrfl_pkg::REQ_LOAD_BEGIN: begin
				c.w = 11'($urandom_range(1, 6));
				c.h = 10'($urandom_range(1, 4));
				if ($urandom_range(19) == 0) begin
					if ($urandom_range(1) != 0) c.w = '0;
					else c.h = '0;
				end
			end
			default: begin
			end
		endcase
		if (c.req == vrfl_pkg::REQ_MOVE && spot_log.size() > 0 && $urandom_range(1) != 0)
		begin
			idx = spot_log[$urandom_range(spot_log.size() - 1)];
			c.x = 10'(idx % VRAM_COLS);
			c.y = 9'(idx / VRAM_COLS);
		end
	endtask

	always @(negedge clk) begin
		blit_resp_t want;
		if (arst_n && done) begin
			if (resp_due.size() == 0) begin
				flag_mismatch("unexpected done beat", read_data, 16'h0);
			end else begin
				want = resp_due.pop_front();
				if (read_data !== want.data)
					flag_mismatch("read_data", read_data, want.data);
				if (load_open !== want.load_flag)
					flag_mismatch("load_open", 16'(load_open), 16'(want.load_flag));
				if (stray_pixel !== want.stray)
					flag_mismatch("stray_pixel", 16'(stray_pixel), 16'(want.stray));
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_CYCLES) begin
			@(negedge clk);
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
		end
		$display("watchdog: no beat for %0d cycles", WATCHDOG_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		blit_cmd_t c;
		int beats;
		arst_n   = 1'b0;
		start    = 1'b0;
		req_type = '0;
		x        = '0;
		y        = '0;
		width    = '0;
		height   = '0;
		dest_x   = '0;
		dest_y   = '0;
		red      = '0;
		green    = '0;
		blue     = '0;
		pixel    = '0;
		calm     = 1'b0;
		load_on  = 1'b0;
		org_col  = 0;
		org_row  = 0;
		span     = 0;
		rows     = 0;
		col_ofs  = 0;
		row_ofs  = 0;
		mismatch_count = 0;
		stray_tally = 0;
		spare_tally = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1357), 1,
			{16'h0000, 1'b0, 1'b1});
		add_row(mk(REQ_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, {16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_FILL, 0, 0, 16, 8, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0), 1,
			{16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			{16'h7FFF, 2'b00});
		add_row(mk(vrfl_pkg::REQ_FILL, 1020, 510, 8, 4, 0, 0, 8'h0F, 8'h07, 8'h00, 0), 1,
			{16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_READ, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			{16'h0001, 2'b00});
		add_row(mk(vrfl_pkg::REQ_FILL, 0, 0, 1024, 1, 0, 0, 8'h00, 8'hFF, 8'h00, 0), 1,
			{16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			{16'h03E0, 2'b00});
		add_row(mk(vrfl_pkg::REQ_FILL, 5, 0, 1, 512, 0, 0, 8'h00, 8'h00, 8'hF8, 0), 1,
			{16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_READ, 5, 511, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			{16'h7C00, 2'b00});
		add_row(mk(vrfl_pkg::REQ_LOAD_BEGIN, 1022, 511, 3, 2, 0, 0, 0, 0, 0, 0), 1,
			{16'h0000, 1'b1, 1'b0});
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1,
			{16'h0000, 1'b1, 1'b0});
		add_row(mk(vrfl_pkg::REQ_READ, 1022, 511, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			{16'hFFFF, 1'b1, 1'b0});
		add_row(mk(REQ_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			{16'h0000, 1'b1, 1'b0});
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000), 0, '0);
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hA5A5), 0, '0);
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h5A5A), 0, '0);
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1234), 0, '0);
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h8001), 0, '0);
		add_row(mk(vrfl_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(vrfl_pkg::REQ_LOAD_BEGIN, 7, 7, 0, 5, 0, 0, 0, 0, 0, 0), 1,
			{16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_LOAD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h4321), 1,
			{16'h0000, 1'b0, 1'b1});
		add_row(mk(vrfl_pkg::REQ_LOAD_BEGIN, 10, 3, 2, 2, 0, 0, 0, 0, 0, 0), 1,
			{16'h0000, 1'b1, 1'b0});
		add_row(mk(vrfl_pkg::REQ_MOVE, 0, 0, 8, 4, 1, 0, 0, 0, 0, 0), 1,
			{16'h0000, 2'b00});
		add_row(mk(vrfl_pkg::REQ_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(vrfl_pkg::REQ_MOVE, 1020, 510, 8, 4, 1023, 511, 0, 0, 0, 0), 0, '0);
		add_row(mk(vrfl_pkg::REQ_READ, 1023, 511, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(vrfl_pkg::REQ_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

		foreach (dir_tab[i]) begin
			send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
		end
		hold_until_drained();

		beats = 0;
		while (beats < RANDOM_BEATS) begin
			calm = (beats >= 400) && (beats < 700);
			if (!calm && $urandom_range(149) == 0) begin
				hold_until_drained();
			end
			pick_random_cmd(c);
			send_cmd(c, 1'b0, '0);
			beats++;
		end
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d fills, %0d load begins, %0d load pixels (%0d stray), %0d moves",
			kind_tally[vrfl_pkg::REQ_FILL], kind_tally[vrfl_pkg::REQ_LOAD_BEGIN],
			kind_tally[vrfl_pkg::REQ_LOAD_PIXEL], stray_tally, kind_tally[vrfl_pkg::REQ_MOVE]);
		$display("  %0d reads, %0d unused codes, wrap on all edges, %0d mismatches",
			kind_tally[vrfl_pkg::REQ_READ], spare_tally, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/vrfl_pkg.sv
design/vrfl_front.sv
design/vrfl_queue.sv
design/vrfl_back.sv
design/vram_rect_fill_load_copy_unit.sv
sim/testbench.sv
